### sv/three_level_priority_queue_macros.svh
// Assertion macros shared by the priority queue modules.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TPLQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle implies consequent at the next edge.
`define TPLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tplq_pkg.sv
// Shared types and constants for the three-level priority queue.
package tplq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int NUM_LVL   = 3;
  localparam int DW        = 32;
  localparam int CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPRIO  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Per-level memory strobes
  typedef struct packed {
    logic [NUM_LVL-1:0] wr_en;
    logic [NUM_LVL-1:0] rd_en;
  } ram_ctl_t;

  // Decision stage result handed to the output register
  typedef struct packed {
    logic    valid;
    status_e status;
    logic [1:0] src;
  } res_t;

endpackage

### sv/tplq_ram.sv
// One queue store: single write port, single registered read port.
module tplq_ram import tplq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/tplq_ctrl.sv
// Queue pointers, counts, depth register and per-word decision stage.
`include "three_level_priority_queue_macros.svh"

module tplq_ctrl import tplq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         cmd_i,
  input  logic [1:0]                   priority_req_i,
  output logic                         in_stall_o,
  input  logic                         cfg_valid_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  output logic                         cfg_ready_o,
  input  logic                         take_i,
  output res_t                         res_o,
  output ram_ctl_t                     ram_ctl_o,
  output logic [NUM_LVL-1:0][AW-1:0]   wr_addr_o,
  output logic [NUM_LVL-1:0][AW-1:0]   rd_addr_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW = ((AW > CW) ? AW : CW) + 1;

  logic [NUM_LVL-1:0][AW-1:0] head_q, head_d, head_inc;
  logic [NUM_LVL-1:0][CW-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0]           depth_q;
  logic                       valid_q;
  status_e                    status_q, status_d;
  logic [1:0]                 src_q, src_d;

  logic                 fire;
  logic [LW-1:0]        lim;
  logic [NUM_LVL-1:0]   full, nonempty, ins_dec, rem_sel;
  logic [SW-1:0]        sum [NUM_LVL];
  ram_ctl_t             ctl;

  // handshake: stall only while the decision register cannot drain
  assign in_stall_o  = valid_q & ~take_i;
  assign fire        = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // effective depth limit
  assign lim = (LW'(depth_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(depth_q);

  // per-level status, tail address and head increment
  always_comb begin
    for (int l = 0; l < NUM_LVL; l++) begin
      full[l]     = LW'(cnt_q[l]) >= lim;
      nonempty[l] = cnt_q[l] != '0;
      sum[l]      = SW'(head_q[l]) + SW'(cnt_q[l]);
      wr_addr_o[l] = (sum[l] >= SW'(DEPTH)) ? AW'(sum[l] - SW'(DEPTH)) : AW'(sum[l]);
      rd_addr_o[l] = head_q[l];
      head_inc[l]  = (head_q[l] == AW'(DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
    end
  end

  // insert target and remove winner (level one first)
  assign ins_dec = {priority_req_i == 2'd3, priority_req_i == 2'd2,
                    priority_req_i == 2'd1};
  assign rem_sel = {nonempty[2] & ~nonempty[1] & ~nonempty[0],
                    nonempty[1] & ~nonempty[0],
                    nonempty[0]};

  // command decision
  always_comb begin
    ctl      = '0;
    status_d = ST_EMPTY;
    src_d    = 2'd0;
    if (cmd_i == CMD_INSERT) begin
      if (priority_req_i == 2'd0) begin
        status_d = ST_BADPRIO;
      end else begin
        src_d = priority_req_i;
        if ((ins_dec & full) != '0) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_INSERTED;
          ctl.wr_en = ins_dec & {NUM_LVL{fire}};
        end
      end
    end else begin
      if (nonempty != '0) begin
        status_d  = ST_REMOVED;
        ctl.rd_en = rem_sel & {NUM_LVL{fire}};
        src_d     = rem_sel[0] ? 2'd1 : (rem_sel[1] ? 2'd2 : 2'd3);
      end
    end
  end

  assign ram_ctl_o = ctl;

  // pointer and count updates
  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    for (int l = 0; l < NUM_LVL; l++) begin
      if (ctl.wr_en[l]) begin
        cnt_d[l] = cnt_q[l] + 1'b1;
      end
      if (ctl.rd_en[l]) begin
        cnt_d[l]  = cnt_q[l] - 1'b1;
        head_d[l] = head_inc[l];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      depth_q <= CFG_RESET;
      valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        depth_q <= cfg_data_i;
      end
      if (fire) begin
        valid_q <= 1'b1;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // decision payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      src_q    <= src_d;
    end
  end

  assign res_o = '{valid: valid_q, status: status_q, src: src_q};

  `TPLQ_ASSERT(a_one_access, $onehot0(ctl.wr_en | ctl.rd_en), "two stores touched by one word")
  `TPLQ_ASSERT_NEXT(a_ins_status, ctl.wr_en != '0, valid_q && status_q == ST_INSERTED, "write without inserted status")
  `TPLQ_ASSERT_NEXT(a_idle_hold, !fire, $stable(cnt_q) && $stable(head_q), "queue state moved without a word")

endmodule

### sv/tplq_oreg.sv
// Output register: takes the decision and read data, holds them under stall.
`include "three_level_priority_queue_macros.svh"

module tplq_oreg import tplq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  res_t                         res_i,
  input  logic [NUM_LVL-1:0][DW-1:0]   rd_data_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic signed [DW-1:0]         data_out_o,
  output logic [1:0]                   source_queue_o
);

  logic          valid_q;
  status_e       status_q;
  logic [1:0]    src_q;
  logic [DW-1:0] data_q, data_d;
  logic          load;

  assign take_o = ~valid_q | ~out_stall_i;
  assign load   = res_i.valid & take_o;

  // pick the read data of the level that gave the word
  always_comb begin
    data_d = '0;
    if (res_i.status == ST_REMOVED) begin
      case (res_i.src)
        2'd1:    data_d = rd_data_i[0];
        2'd2:    data_d = rd_data_i[1];
        2'd3:    data_d = rd_data_i[2];
        default: data_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res_i.status;
      src_q    <= res_i.src;
      data_q   <= data_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign data_out_o     = data_q;
  assign source_queue_o = src_q;

  `TPLQ_ASSERT(a_zero_data, !valid_q || status_q == ST_REMOVED || data_q == '0, "data on a non-remove word")

endmodule

### sv/three_level_priority_queue.sv
// Three-level strict-priority queue: top level.
//
// Input channel (in_valid_i / in_stall_o) carries one command word: cmd_i
// (0 insert, 1 remove), priority_req_i (1 highest .. 3 lowest) and data_in_i.
// Output channel (out_valid_o / out_stall_i) returns one result word per
// command: status_o, data_out_o and source_queue_o.
// Config channel (cfg_valid_i / cfg_ready_o) writes the per-queue depth
// limit; it is always ready and must only be used while the block is idle.
// An accepted command passes through the decision register, then the output
// register, which also takes the store read data.
// One command is accepted per cycle while in_stall_o is low; each command
// touches at most one entry of one store and one pointer/count pair.
// A stalled result stays in the output register while one more command is
// taken into the decision register; after that in_stall_o rises.
// Reset clears pointers, counts and valid flags and sets the depth limit to
// 64. Store contents are not cleared; entries are only read after a write.
module three_level_priority_queue import tplq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [1:0]           priority_req_i,
  input  logic signed [DW-1:0] data_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic signed [DW-1:0] data_out_o,
  output logic [1:0]           source_queue_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  res_t                       res;
  ram_ctl_t                   ram_ctl;
  logic                       take;
  logic [NUM_LVL-1:0][AW-1:0] wr_addr, rd_addr;
  logic [NUM_LVL-1:0][DW-1:0] rd_data;

  tplq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .cmd_i          (cmd_i),
    .priority_req_i (priority_req_i),
    .in_stall_o     (in_stall_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .take_i         (take),
    .res_o          (res),
    .ram_ctl_o      (ram_ctl),
    .wr_addr_o      (wr_addr),
    .rd_addr_o      (rd_addr)
  );

  // one store per priority level
  for (genvar l = 0; l < NUM_LVL; l++) begin : g_store
    tplq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (ram_ctl.wr_en[l]),
      .wr_addr_i (wr_addr[l]),
      .wr_data_i (data_in_i),
      .rd_en_i   (ram_ctl.rd_en[l]),
      .rd_addr_i (rd_addr[l]),
      .rd_data_o (rd_data[l])
    );
  end

  tplq_oreg u_oreg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .rd_data_i      (rd_data),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .source_queue_o (source_queue_o)
  );

endmodule

### test/three_level_priority_queue_tb.sv
// Self-checking testbench for the three-level strict-priority queue.
`timescale 1ns / 100ps

module three_level_priority_queue_tb;
  import tplq_pkg::*;

  localparam int IDX_W       = $clog2(DEPTH_DEF);
  localparam int QUIET_LIMIT = 1000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [1:0] PRIO_NONE = 2'd0;

  // Expected result word
  typedef struct packed {
    status_e       status;
    logic [DW-1:0] data;
    logic [1:0]    src;
  } qres_t;

  typedef enum logic {ROW_WORD, ROW_DEPTH} row_kind_e;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  // Directed stimulus row; a depth row carries the new limit in data
  typedef struct {
    row_kind_e     kind;
    logic          cmd;
    logic [1:0]    prio;
    logic [DW-1:0] data;
    bit            typed;
    qres_t         want;
  } row_t;

  localparam qres_t EMPTY_R = '{ST_EMPTY, 32'h0, 2'd0};
  localparam qres_t BADP_R  = '{ST_BADPRIO, 32'h0, 2'd0};
  localparam int NUM_ROWS = 27;

  row_t dir_rows [NUM_ROWS] = '{
    // after reset, extremes of data on every level
    '{ROW_WORD, CMD_REMOVE, 2'd0, 32'h0000_0000, 1'b1, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, PRIO_NONE, 32'h0000_007B, 1'b1, BADP_R},
    '{ROW_WORD, CMD_INSERT, 2'd3, 32'h8000_0000, 1'b1, '{ST_INSERTED, 32'h0, 2'd3}},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'h7FFF_FFFF, 1'b1, '{ST_INSERTED, 32'h0, 2'd2}},
    '{ROW_WORD, CMD_INSERT, 2'd1, 32'h0000_0000, 1'b1, '{ST_INSERTED, 32'h0, 2'd1}},
    '{ROW_WORD, CMD_INSERT, 2'd1, 32'hFFFF_FFFF, 1'b1, '{ST_INSERTED, 32'h0, 2'd1}},
    '{ROW_WORD, CMD_REMOVE, 2'd3, 32'h1234_5678, 1'b1, '{ST_REMOVED, 32'h0, 2'd1}},
    '{ROW_WORD, CMD_REMOVE, 2'd0, 32'h0000_0000, 1'b1, '{ST_REMOVED, 32'hFFFF_FFFF, 2'd1}},
    '{ROW_WORD, CMD_REMOVE, 2'd2, 32'hFFFF_FFFF, 1'b1, '{ST_REMOVED, 32'h7FFF_FFFF, 2'd2}},
    '{ROW_WORD, CMD_REMOVE, 2'd1, 32'h0000_0000, 1'b1, '{ST_REMOVED, 32'h8000_0000, 2'd3}},
    '{ROW_WORD, CMD_REMOVE, 2'd3, 32'hAAAA_AAAA, 1'b1, EMPTY_R},
    // small limit, then fill level 2 past it
    '{ROW_DEPTH, CMD_INSERT, 2'd0, 32'd3, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'h5555_5555, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'hAAAA_AAAA, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'h0F0F_0F0F, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'hF0F0_F0F0, 1'b1, '{ST_FULL, 32'h0, 2'd2}},
    // limit lowered below the held count
    '{ROW_DEPTH, CMD_INSERT, 2'd0, 32'd1, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd2, 32'h1357_9BDF, 1'b1, '{ST_FULL, 32'h0, 2'd2}},
    '{ROW_WORD, CMD_REMOVE, 2'd1, 32'h2468_ACE0, 1'b0, EMPTY_R},
    // zero limit: every insert with a valid priority is full, drains still work
    '{ROW_DEPTH, CMD_INSERT, 2'd0, 32'd0, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_INSERT, 2'd1, 32'hDEAD_BEEF, 1'b1, '{ST_FULL, 32'h0, 2'd1}},
    '{ROW_WORD, CMD_INSERT, 2'd3, 32'h0000_0001, 1'b1, '{ST_FULL, 32'h0, 2'd3}},
    '{ROW_WORD, CMD_INSERT, PRIO_NONE, 32'h8000_0001, 1'b1, BADP_R},
    '{ROW_WORD, CMD_REMOVE, 2'd2, 32'h0000_0000, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_REMOVE, 2'd3, 32'h0000_0000, 1'b0, EMPTY_R},
    '{ROW_WORD, CMD_REMOVE, 2'd0, 32'h0000_0000, 1'b1, EMPTY_R},
    // limit above the store size
    '{ROW_DEPTH, CMD_INSERT, 2'd0, 32'd127, 1'b0, EMPTY_R}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [1:0]           in_prio;
  logic [DW-1:0]        in_data;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           status;
  logic [DW-1:0]        data_out;
  logic [1:0]           source_queue;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data;

  // typed expectation riding along with the command word
  bit                   row_typed;
  qres_t                row_want;
  bit                   gaps_on;

  // Shadow state of the queues
  logic [DW-1:0]        lvl_store [NUM_LVL][DEPTH_DEF];
  logic [IDX_W-1:0]     head_ptr [NUM_LVL] = '{default: '0};
  logic [CFG_W-1:0]     fill_count [NUM_LVL] = '{default: '0};
  logic [CFG_W-1:0]     depth_shadow = CFG_RESET;

  qres_t                pending_results [$];
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;

  three_level_priority_queue #(
    .DEPTH(DEPTH_DEF)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (in_cmd),
    .priority_req_i (in_prio),
    .data_in_i      (in_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .data_out_o     (data_out),
    .source_queue_o (source_queue),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow queues and return the result word
  function automatic qres_t apply_command(input logic c, input logic [1:0] p,
                                          input logic [DW-1:0] d);
    qres_t r;
    logic [CFG_W-1:0] lim;
    int q;
    r = EMPTY_R;
    lim = (depth_shadow > CFG_W'(DEPTH_DEF)) ? CFG_W'(DEPTH_DEF) : depth_shadow;
    if (c == CMD_INSERT) begin
      if (p == PRIO_NONE) begin
        r.status = ST_BADPRIO;
      end else begin
        q = int'(p) - 1;
        r.src = p;
        if (fill_count[q] >= lim) begin
          r.status = ST_FULL;
        end else begin
          lvl_store[q][IDX_W'(head_ptr[q] + fill_count[q])] = d;
          fill_count[q] = fill_count[q] + 1'b1;
          r.status = ST_INSERTED;
        end
      end
    end else begin
      // level 1 first, oldest entry of the first non-empty level
      for (q = 0; q < NUM_LVL; q++) begin
        if (r.status == ST_EMPTY && fill_count[q] != 0) begin
          r.data = lvl_store[q][head_ptr[q]];
          head_ptr[q] = head_ptr[q] + 1'b1;
          fill_count[q] = fill_count[q] - 1'b1;
          r.src = 2'(q + 1);
          r.status = ST_REMOVED;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one command word and hold it until taken
  task automatic push_word(input logic c, input logic [1:0] p, input logic [DW-1:0] d,
                           input bit typed, input qres_t want);
    in_valid  <= 1'b1;
    in_cmd    <= c;
    in_prio   <= p;
    in_data   <= d;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_depth(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Random commands; fill and drain mixes push the queues to full and empty
  task automatic run_phase(input int n, input mix_e mix);
    int k;
    int ins_pct;
    logic [1:0] fav;
    logic c;
    logic [1:0] p;
    ins_pct = (mix == MIX_FILL) ? 95 : (mix == MIX_DRAIN) ? 20 : 50;
    fav = 2'($urandom_range(1, 3));
    for (k = 0; k < n; k++) begin
      c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
      p = 2'($urandom_range(0, 3));
      if (mix == MIX_FILL && $urandom_range(0, 9) != 0) p = fav;
      push_word(c, p, $urandom(), 1'b0, EMPTY_R);
      if (gaps_on && $urandom_range(0, 63) == 0) wait_drained();
    end
  endtask

  // Receiver stall bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Track accepted commands, config writes and check returned words
  always @(posedge clk) begin : result_check
    qres_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested word, status", DW'(status), '0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", DW'(status), DW'(want.status));
          if (data_out !== want.data)
            report_mismatch("data_out", data_out, want.data);
          if (source_queue !== want.src)
            report_mismatch("source_queue", DW'(source_queue), DW'(want.src));
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        want = apply_command(in_cmd, in_prio, in_data);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
      end
      if (cfg_valid && cfg_ready === 1'b1) depth_shadow = cfg_data;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int r;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_cmd    <= CMD_INSERT;
    in_prio   <= PRIO_NONE;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    row_typed <= 1'b0;
    row_want  <= EMPTY_R;
    gaps_on        = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_DEPTH)
        set_depth(dir_rows[r].data[CFG_W-1:0]);
      else
        push_word(dir_rows[r].cmd, dir_rows[r].prio, dir_rows[r].data,
                  dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases over several limits; fill/drain wraps the pointers
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(110, MIX_FILL);
    run_phase(90, MIX_DRAIN);
    set_depth(7'd64);
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(110, MIX_FILL);
    run_phase(90, MIX_DRAIN);
    set_depth(7'd1);
    gaps_on = ($urandom_range(0, 3) != 0);
    run_phase(80, MIX_EVEN);
    set_depth(7'd0);
    run_phase(30, MIX_EVEN);
    set_depth(CFG_W'($urandom_range(2, 63)));
    gaps_on = 1'b1;
    run_phase(90, MIX_EVEN);
    gaps_on = 1'b0;
    run_phase(60, MIX_EVEN);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### three_level_priority_queue.f
+incdir+sv
sv/tplq_pkg.sv
sv/tplq_ram.sv
sv/tplq_ctrl.sv
sv/tplq_oreg.sv
sv/three_level_priority_queue.sv
test/three_level_priority_queue_tb.sv
